/* rtl/core/mswf_pkg.sv */
package mswf_pkg;

   // default capacity of the ring store
   localparam int DEPTH_DEFAULT = 16;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [7:0] SWITCH_CODE_RESET = 8'hFF;
   localparam logic REG_SWITCH_CODE = 1'b0;

   // request commands
   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_PUT       = 3'd0;
   localparam logic [2:0] STATUS_OVERWRITE = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_DELIVER   = 3'd3;
   localparam logic [2:0] STATUS_SWITCH    = 3'd4;

   typedef struct packed {
      logic       cmd;
      logic [7:0] put_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] data_out;
      logic       domain;
      logic       mode_now;
      logic [4:0] fill_level;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic put;
      logic get_empty;
      logic get_fetch;
      logic get_eval;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
   } dp_stat_type;

endpackage

/* rtl/core/mode_switching_overwrite_fifo.sv */
// Overwriting byte ring buffer with a mode-switch code.
// Request channel (req_valid, req_stall, req_data): a put stores put_byte, and
// on a full buffer overwrites the oldest byte; a get pops the oldest byte.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response per
// request, carrying status, popped byte, its domain, current mode and fill level.
// A popped byte equal to switch_code toggles the mode and empties the buffer.
// APB port: switch_code at byte address 0, pready tied high.
// A put or a get on an empty buffer shows its response in the cycle after the
// request is taken; a get on a non-empty buffer passes first through the
// registered read of the byte store and then through the switch-code compare.
// Throughput: one put per cycle while the response is not stalled.
// A stalled response holds off the next request: a request waits while the
// response register is full and the receiver keeps rsp_stall high, and for the
// compare step (ST_EVAL) that follows a non-empty get.
// Reset clears pointers, fill count and mode (low domain) and sets switch_code
// to 255; the byte store is not cleared, as entries are read only once written.
module mode_switching_overwrite_fifo
   import mswf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign pready = 1'b1;

   // handshake and sequencing
   mswf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, pointers, mode and configuration
   mswf_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata)
   );

endmodule

/* rtl/core/mswf_dp.sv */
module mswf_dp
   import mswf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             mode_ff, mode_in;
   logic [7:0]       switch_code_ff, switch_code_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_load;
   logic             full;
   logic             is_switch;
   logic [CNT_W+4:0] count_pad;
   logic [PTR_W-1:0] rptr_next;
   logic [PTR_W-1:0] wptr_next;

   // wrapping pointer increments
   assign rptr_next = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + PTR_W'(1);
   assign wptr_next = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + PTR_W'(1);

   assign full       = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);
   assign is_switch  = (rd_data_ff == switch_code_ff);

   // pointer, count and mode updates
   always_comb begin
      rptr_in  = rptr_ff;
      wptr_in  = wptr_ff;
      count_in = count_ff;
      mode_in  = mode_ff;
      if (cmd.put) begin
         wptr_in = wptr_next;
         if (full) begin
            rptr_in = rptr_next;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.get_fetch) begin
         rptr_in  = rptr_next;
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.get_eval && is_switch) begin
         rptr_in  = wptr_ff;
         count_in = '0;
         mode_in  = ~mode_ff;
      end
   end

   // fill level is the count masked to five bits
   assign count_pad = {5'b0, count_in};

   // result assembly
   assign rsp_load = cmd.put || cmd.get_empty || cmd.get_eval;
   always_comb begin
      rsp_in            = rsp_ff;
      if (rsp_load) begin
         rsp_in.data_out   = '0;
         rsp_in.domain     = 1'b0;
         rsp_in.mode_now   = mode_in;
         rsp_in.fill_level = count_pad[4:0];
         if (cmd.put) begin
            rsp_in.status = full ? STATUS_OVERWRITE : STATUS_PUT;
         end else if (cmd.get_empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else if (is_switch) begin
            rsp_in.status = STATUS_SWITCH;
         end else begin
            rsp_in.status   = STATUS_DELIVER;
            rsp_in.data_out = rd_data_ff;
            rsp_in.domain   = mode_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

   // configuration register
   always_comb begin
      switch_code_in = switch_code_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_SWITCH_CODE)) begin
         switch_code_in = pwdata[7:0];
      end
   end

   assign prdata = (paddr[2] == REG_SWITCH_CODE) ?
                   {{(CSR_DATA_W-8){1'b0}}, switch_code_ff} : '0;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff        <= '0;
         wptr_ff        <= '0;
         count_ff       <= '0;
         mode_ff        <= 1'b0;
         switch_code_ff <= SWITCH_CODE_RESET;
      end else begin
         rptr_ff        <= rptr_in;
         wptr_ff        <= wptr_in;
         count_ff       <= count_in;
         mode_ff        <= mode_in;
         switch_code_ff <= switch_code_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // byte store, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         mem[wptr_ff] <= req_data.put_byte;
      end
      if (cmd.get_fetch) begin
         rd_data_ff <= mem[rptr_ff];
      end
   end

   // fill count stays within capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("fill count above capacity");

   // a mode switch always leaves the store empty
   assert property (@(posedge clock) disable iff (reset)
                    (cmd.get_eval && is_switch) |=> (count_ff == '0) && (rptr_ff == wptr_ff))
      else $error("store not cleared after mode switch");

   // a put on a full store keeps it full
   assert property (@(posedge clock) disable iff (reset)
                    (cmd.put && full) |=> full)
      else $error("overwrite changed the fill count");

endmodule

/* rtl/core/mswf_ctrl.sv */
module mswf_ctrl
   import mswf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;
   logic is_get;

   // request is taken only when idle and the result register can take a result
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign is_get    = (req_data.cmd == CMD_GET);

   // datapath commands
   assign cmd.put       = accept && !is_get;
   assign cmd.get_empty = accept && is_get && stat.empty;
   assign cmd.get_fetch = accept && is_get && !stat.empty;
   assign cmd.get_eval  = (state_ff == ST_EVAL);

   // next state
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = cmd.get_fetch ? ST_EVAL : ST_IDLE;
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.put || cmd.get_empty || cmd.get_eval) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // evaluation only follows a fetch
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_EVAL) |-> $past(cmd.get_fetch))
      else $error("evaluation without fetch");

   // result register is free when a fetched byte is evaluated
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_EVAL) |-> !rsp_valid_ff)
      else $error("result register busy during evaluation");

   // at most one datapath command per cycle
   assert property (@(posedge clock) disable iff (reset)
                    $onehot0({cmd.put, cmd.get_empty, cmd.get_fetch, cmd.get_eval}))
      else $error("conflicting datapath commands");

endmodule

/* tb/tb_mode_switching_overwrite_fifo.sv */
`timescale 1ns / 100ps

module tb_mode_switching_overwrite_fifo;
   import mswf_pkg::*;

   localparam int RING_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_ADDR_W-1:0] SWITCH_CODE_ADDR = CSR_ADDR_W'(4 * REG_SWITCH_CODE);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CSR_ADDR_W'(4 * (REG_SWITCH_CODE + 1));

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predicted ring contents, pointers, mode and switch code
   logic [7:0] ring_bytes [RING_DEPTH];
   int         ring_rd = 0;
   int         ring_wr = 0;
   int         ring_fill = 0;
   logic       ring_mode = 1'b0;
   logic [7:0] switch_code = SWITCH_CODE_RESET;

   // responses still owed by the block, oldest first
   rsp_type awaited_rsps [$];

   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off_cycles = 0;
   int unsigned cycle_count = 0;

   mode_switching_overwrite_fifo uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   function automatic req_type make_request(logic cmd, logic [7:0] value);
      req_type r;
      r.cmd = cmd;
      r.put_byte = value;
      return r;
   endfunction

   // response of the ring to one request, advancing the predicted state
   function automatic rsp_type ring_step(req_type r);
      rsp_type    o;
      logic [7:0] popped;
      o = '0;
      if (r.cmd == CMD_PUT) begin
         ring_bytes[ring_wr] = r.put_byte;
         ring_wr = (ring_wr + 1) % RING_DEPTH;
         if (ring_fill == RING_DEPTH) begin
            // full: oldest byte is lost
            ring_rd = (ring_rd + 1) % RING_DEPTH;
            o.status = STATUS_OVERWRITE;
         end else begin
            ring_fill++;
            o.status = STATUS_PUT;
         end
      end else if (ring_fill == 0) begin
         o.status = STATUS_EMPTY;
      end else begin
         popped = ring_bytes[ring_rd];
         ring_rd = (ring_rd + 1) % RING_DEPTH;
         ring_fill--;
         if (popped == switch_code) begin
            // code byte is consumed, mode flips and the ring empties
            ring_mode = ~ring_mode;
            ring_rd = ring_wr;
            ring_fill = 0;
            o.status = STATUS_SWITCH;
         end else begin
            o.status = STATUS_DELIVER;
            o.data_out = popped;
            o.domain = ring_mode;
         end
      end
      o.mode_now = ring_mode;
      o.fill_level = 5'(ring_fill);
      return o;
   endfunction

   function automatic void flag_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
   endfunction

   // response check against the oldest prediction
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsps.size() == 0) begin
            flag_mismatch("response with none pending", 0, rsp_data);
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch("status", want.status, rsp_data.status);
            if (rsp_data.data_out !== want.data_out)
               flag_mismatch("data_out", want.data_out, rsp_data.data_out);
            if (rsp_data.domain !== want.domain)
               flag_mismatch("domain", want.domain, rsp_data.domain);
            if (rsp_data.mode_now !== want.mode_now)
               flag_mismatch("mode_now", want.mode_now, rsp_data.mode_now);
            if (rsp_data.fill_level !== want.fill_level)
               flag_mismatch("fill_level", want.fill_level, rsp_data.fill_level);
         end
      end
   end

   // receiver stalls, with a long hold-off when one is asked for
   initial begin : drive_rsp_stall
      int gap;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            gap = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            gap = pick_gap(recv_stall_pct);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // offer one request, predict its response once taken; valid stays high
   task automatic send_request(req_type r);
      int gap;
      gap = pick_gap(send_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_rsps.push_back(ring_step(r));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == SWITCH_CODE_ADDR) switch_code = value[7:0];
   endtask

   task automatic csr_read_check(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) flag_mismatch("prdata", want, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_switch_code(logic [7:0] code);
      wait_drained();
      csr_write(SWITCH_CODE_ADDR, CSR_DATA_W'(code));
      csr_read_check(SWITCH_CODE_ADDR, CSR_DATA_W'(code));
   endtask

   // empty get, in-order delivery and a switch that clears the ring
   task automatic test_empty_and_switch();
      send_request(make_request(CMD_GET, 8'h00));
      send_request(make_request(CMD_PUT, 8'h00));
      send_request(make_request(CMD_PUT, 8'hFF));
      send_request(make_request(CMD_PUT, 8'h5A));
      send_request(make_request(CMD_GET, 8'hFF));
      send_request(make_request(CMD_GET, 8'h00));
      send_request(make_request(CMD_GET, 8'hA5));
      wait_drained();
   endtask

   // fill past capacity so the oldest byte is overwritten, then pop
   task automatic test_overwrite_when_full();
      for (int i = 0; i <= RING_DEPTH; i++)
         send_request(make_request(CMD_PUT, 8'(i * 15)));
      send_request(make_request(CMD_GET, 8'h00));
      wait_drained();
   endtask

   // a write outside the register map leaves the switch code alone
   task automatic test_register_access();
      set_switch_code(8'h00);
      csr_write(UNMAPPED_ADDR, CSR_DATA_W'(8'hAB));
      csr_read_check(SWITCH_CODE_ADDR, CSR_DATA_W'(8'h00));
   endtask

   // random puts and gets under one switch code and idling mix
   task automatic test_random_traffic(logic [7:0] code, int put_pct, int count,
                                      int idle_pct, int stall_pct);
      logic       cmd;
      logic [7:0] value;
      set_switch_code(code);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         cmd   = ($urandom_range(99) < put_pct) ? CMD_PUT : CMD_GET;
         value = ($urandom_range(99) < 8) ? switch_code : 8'($urandom_range(255));
         send_request(make_request(cmd, value));
      end
      wait_drained();
   endtask

   // receiver holds off long enough that the block stalls its requests
   task automatic test_full_backpressure();
      logic cmd;
      wait_drained();
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 80;
      repeat (60) begin
         cmd = ($urandom_range(99) < 70) ? CMD_PUT : CMD_GET;
         send_request(make_request(cmd, 8'($urandom_range(255))));
      end
      wait_drained();
   endtask

   initial begin : run_tests
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_switch();
      test_overwrite_when_full();
      test_register_access();
      test_random_traffic(8'h00, 75, 300, 0, 0);
      test_random_traffic(8'hFF, 60, 300, 20, 20);
      test_random_traffic(8'h80, 40, 300, 30, 30);
      test_full_backpressure();
      test_random_traffic(8'($urandom_range(254, 1)), 55, 400, 10, 40);
      test_random_traffic(8'hFF, 50, 300, 40, 10);
      test_random_traffic(8'($urandom_range(254, 1)), 65, 200, 15, 15);

      wait_drained();
      if (mismatch_count == 0 && awaited_rsps.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/mswf_pkg.sv
rtl/core/mswf_dp.sv
rtl/core/mswf_ctrl.sv
rtl/core/mode_switching_overwrite_fifo.sv
tb/tb_mode_switching_overwrite_fifo.sv
